/* rtl/core/sols_pkg.sv */
// Package for the self-organising key table search block.
// Holds sizes, request/result payload types, cell command and hit types.
// No dependencies.
`timescale 1ns / 1ps

package sols_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BITS    = 16;
    localparam int POS_BITS    = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TREE_LEAVES = 1 << IDX_W;
    localparam int LAT_W       = $clog2(IDX_W + 1);

    // Request operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Reorder mode codes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MTF  = 2'd1;
    localparam logic [1:0] MODE_SWAP = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [KEY_BITS-1:0] key;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
        logic                full_error;
    } t_res;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_WRITE,
        CMD_MTF,
        CMD_SWAP
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [KEY_BITS-1:0] key;
        logic [IDX_W-1:0]    hit;
        logic [CNT_W-1:0]    count;
    } t_cell_cmd;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_hit;

endpackage

/* rtl/core/sols_cell.sv */
// One table cell: holds a key, compares it with the broadcast key and
// takes a new key on append, move-to-front shift or swap. Uses sols_pkg.
`timescale 1ns / 1ps

module sols_cell
    import sols_pkg::*;
(
    input  logic                i_clk,
    input  logic [IDX_W-1:0]    i_idx,
    input  t_cell_cmd           i_cmd,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic [KEY_BITS-1:0] i_first_key,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_match
);

    logic [KEY_BITS-1:0] r_key;
    logic                r_match;
    logic                w_is_first;
    logic                w_in_use;

    assign w_is_first = (i_idx == '0);
    assign w_in_use   = (CNT_W'(i_idx) < i_cmd.count);

    // Compare against the broadcast key every cycle
    always_ff @(posedge i_clk) begin
        r_match <= w_in_use && (r_key == i_cmd.key);
    end

    // Update the stored key as commanded
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_WRITE: begin
                if (CNT_W'(i_idx) == i_cmd.count) begin
                    r_key <= i_cmd.key;
                end
            end
            CMD_MTF: begin
                if (w_is_first) begin
                    r_key <= i_cmd.key;
                end else if (i_idx <= i_cmd.hit) begin
                    r_key <= i_prev_key;
                end
            end
            CMD_SWAP: begin
                if (w_is_first) begin
                    r_key <= i_cmd.key;
                end else if (i_idx == i_cmd.hit) begin
                    r_key <= i_first_key;
                end
            end
            default: begin
                r_key <= r_key;
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

/* rtl/core/sols_ptree.sv */
// Registered priority tree: finds the lowest-index set match bit, with
// a register at each tree level. Uses sols_pkg.
`timescale 1ns / 1ps

module sols_ptree
    import sols_pkg::*;
(
    input  logic                   i_clk,
    input  logic [TABLE_DEPTH-1:0] i_match,
    output t_hit                   o_hit
);

    logic [TREE_LEAVES-1:0] w_leaf;
    t_hit                   r_node [1:TREE_LEAVES-1];

    // Pad the leaves up to a power of two
    for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
        if (i < TABLE_DEPTH) begin : g_used
            assign w_leaf[i] = i_match[i];
        end else begin : g_pad
            assign w_leaf[i] = 1'b0;
        end
    end

    // Each node keeps the left child when it holds a match
    for (genvar n = 1; n < TREE_LEAVES; n++) begin : g_node
        if (2 * n >= TREE_LEAVES) begin : g_bottom
            always_ff @(posedge i_clk) begin
                r_node[n].valid <= w_leaf[2*n-TREE_LEAVES] | w_leaf[2*n+1-TREE_LEAVES];
                r_node[n].idx   <= w_leaf[2*n-TREE_LEAVES] ? IDX_W'(2*n-TREE_LEAVES)
                                                           : IDX_W'(2*n+1-TREE_LEAVES);
            end
        end else begin : g_upper
            always_ff @(posedge i_clk) begin
                r_node[n].valid <= r_node[2*n].valid | r_node[2*n+1].valid;
                r_node[n].idx   <= r_node[2*n].valid ? r_node[2*n].idx
                                                     : r_node[2*n+1].idx;
            end
        end
    end

    assign o_hit = r_node[1];

endmodule

/* rtl/core/self_organizing_list_search.sv */
// Self-organising key table with search and optional reordering.
// Top level: sequencer, row of sols_cell, sols_ptree. Uses sols_pkg.
//
// Usage:
//   Request channel (i_valid, i_req, o_stall): an append writes the key at
//   the table end, a search looks for the key from index 0 upward.
//   Result channel (o_valid, o_res, i_stall): one result per request,
//   held steady while i_stall is high.
//   i_cfg_we/i_cfg_wdata write the reorder mode; write only while idle.
// Timing:
//   One request is handled at a time. After a search is accepted the key
//   passes the cell compare register, the registered levels of the priority
//   tree, the apply state and the result load; an append skips the compare
//   and the tree. The next request is taken the cycle after the result is
//   loaded, even if the receiver still stalls; a result still stalled holds
//   the following one back.
// Reset:
//   Clears the entry count, reorder mode and handshake state; table
//   contents are only read below the entry count.
`timescale 1ns / 1ps

module self_organizing_list_search
    import sols_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_req       i_req,
    output logic       o_stall,
    output logic       o_valid,
    output t_res       o_res,
    input  logic       i_stall,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic [1:0]          r_mode;
    logic [LAT_W-1:0]    r_lat_cnt;
    t_res                r_pend;
    t_res                r_out;
    logic                r_out_valid;

    t_cell_cmd              w_cmd;
    logic [KEY_BITS-1:0]    w_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match;
    t_hit                   w_hit;
    logic                   w_full;
    logic                   w_accept;

    assign w_full   = (r_count >= CNT_W'(TABLE_DEPTH));
    assign w_accept = i_valid && !o_stall;

    // Build the command broadcast to every cell
    always_comb begin
        w_cmd.op    = CMD_HOLD;
        w_cmd.key   = r_key;
        w_cmd.hit   = w_hit.idx;
        w_cmd.count = r_count;
        if (r_state == S_APPLY) begin
            if (r_op == OP_APPEND) begin
                if (!w_full) begin
                    w_cmd.op = CMD_WRITE;
                end
            end else if (w_hit.valid) begin
                unique case (r_mode)
                    MODE_MTF:  w_cmd.op = CMD_MTF;
                    MODE_SWAP: w_cmd.op = CMD_SWAP;
                    default:   w_cmd.op = CMD_HOLD;
                endcase
            end
        end
    end

    // Row of cells, each fed by its lower neighbour
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        sols_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (IDX_W'(i)),
            .i_cmd       (w_cmd),
            .i_prev_key  (w_key[(i == 0) ? 0 : i - 1]),
            .i_first_key (w_key[0]),
            .o_key       (w_key[i]),
            .o_match     (w_match[i])
        );
    end

    sols_ptree u_ptree (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_hit   (w_hit)
    );

    // Hold the reorder mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Sequencer, entry count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lat_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one is loaded this cycle
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_req.operation;
                        r_key     <= i_req.key;
                        r_lat_cnt <= '0;
                        r_state   <= (i_req.operation == OP_SEARCH) ? S_SCAN : S_APPLY;
                    end
                end
                S_SCAN: begin
                    if (r_lat_cnt == LAT_W'(IDX_W)) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_lat_cnt <= r_lat_cnt + LAT_W'(1);
                    end
                end
                S_APPLY: begin
                    if (r_op == OP_APPEND) begin
                        r_pend.found      <= 1'b0;
                        r_pend.position   <= '0;
                        r_pend.full_error <= w_full;
                        if (!w_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end else begin
                        r_pend.found      <= w_hit.valid;
                        r_pend.position   <= w_hit.valid ? POS_BITS'(w_hit.idx) : '0;
                        r_pend.full_error <= 1'b0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
